FILE: rtl/cnb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnb_pkg
// Shared constants, codes and types of the categorical naive Bayes core.
// ----------------------------------------------------------------------------
package cnb_pkg;

  localparam int MAX_CLASSES  = 8;
  localparam int MAX_FEATURES = 64;
  localparam int MAX_VALUES   = 16;
  localparam int COUNT_WIDTH  = 48;

  localparam int CLASS_W   = $clog2(MAX_CLASSES);
  localparam int FEAT_W    = $clog2(MAX_FEATURES);
  localparam int VAL_W     = $clog2(MAX_VALUES);
  localparam int ENT_W     = FEAT_W + VAL_W;
  localparam int CNT_AW    = CLASS_W + ENT_W;
  localparam int CNT_DEPTH = MAX_CLASSES * MAX_FEATURES * MAX_VALUES;
  localparam int CARD_W    = VAL_W + 1;

  localparam int OPCODE_W = 3;
  localparam int CIDX_W   = 3;
  localparam int FIDX_W   = 6;
  localparam int FVAL_W   = 5;
  localparam int AMT_W    = 24;
  localparam int CCNT_W   = 4;
  localparam int FCNT_W   = 7;
  localparam int PROB_W   = 17;
  localparam int STAT_W   = 2;
  localparam int CFG_IW   = 2;
  localparam int CFG_DW   = 24;

  localparam int Q_FRAC      = 16;
  localparam int Q16_ONE     = 65536;
  localparam int SUM_TOL     = 1;
  localparam int SUM_W       = AMT_W + CLASS_W;
  localparam int MANT_W      = 32;
  localparam int WIDE_W      = COUNT_WIDTH + 1;
  localparam int EXP_W       = 14;
  localparam int TOTAL_W     = MANT_W + CLASS_W;
  localparam int DIVD_W      = 64;
  localparam int DIVS_W      = 40;
  localparam int ALIGN_LIMIT = 40;
  localparam int SH_W        = $clog2(ALIGN_LIMIT);

  localparam logic [OPCODE_W-1:0] OP_SET_LABEL   = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_SET_FEATURE = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_TRAIN       = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_PREDICT     = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_FORGET      = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_SET_CARD    = 3'd5;

  localparam logic [STAT_W-1:0] ST_PREDICT   = 2'd0;
  localparam logic [STAT_W-1:0] ST_TRAIN_OK  = 2'd1;
  localparam logic [STAT_W-1:0] ST_TRAIN_REJ = 2'd2;

  localparam logic [CFG_IW-1:0] REG_CLASS_COUNT   = 2'd0;
  localparam logic [CFG_IW-1:0] REG_FEATURE_COUNT = 2'd1;
  localparam logic [CFG_IW-1:0] REG_ALPHA         = 2'd2;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_EXEC, S_SUM, S_SUM_CHK,
    S_TR_TOTAL, S_TR_FREAD, S_TR_CREAD, S_TR_WRITE, S_TR_RESULT,
    S_PR_INIT, S_PR_NORM, S_PF_FREAD, S_PF_CREAD, S_PF_NUM, S_PF_SHIFT,
    S_PF_SKIP, S_PF_DIV, S_PF_WAIT, S_PF_MUL, S_PF_PROD, S_PR_STORE,
    S_AL, S_PO_DIV, S_PO_WAIT, S_PO_OUT,
    S_FG_TOTAL, S_FG_TWAIT, S_FG_TSET, S_FG_READ, S_FG_DIV, S_FG_WAIT
  } state_t;

  typedef enum logic [4:0] {
    U_IDLE, U_CLEAR, U_EXEC, U_SUM, U_NOP,
    U_TR_TOTAL, U_FREAD, U_CREAD, U_TR_WRITE, U_TR_RESULT,
    U_PR_INIT, U_NORM, U_PF_NUM, U_PF_SHIFT, U_F_NEXT, U_PF_DIV,
    U_PF_MUL, U_PF_PROD, U_PR_STORE, U_AL, U_PO_DIV, U_PO_OUT,
    U_FG_TOTAL, U_FG_TSET, U_FG_READ, U_FG_DIV, U_FG_WRITE
  } uop_t;

  typedef struct packed {
    uop_t uop;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic                clear_last;
    logic                c_last;
    logic                f_last;
    logic                f_end;
    logic                e_last;
    logic                sum_ok;
    logic                norm_done;
    logic                m_zero;
    logic                den_zero;
    logic                den_small;
    logic                div_busy;
    logic                out_free;
    logic                amt_zero;
    logic [OPCODE_W-1:0] op;
  } stat_t;

endpackage

FILE: rtl/cnb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnb_ram
// Single-port RAM, one address per cycle, registered read data.
// ----------------------------------------------------------------------------
module cnb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/cnb_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnb_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cnb_div import cnb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIVS_W-1:0] divisor,
  output logic              busy,
  output logic [DIVD_W-1:0] quot
);

  logic [DIVD_W-1:0]         dq;
  logic [DIVS_W-1:0]         rem;
  logic [DIVS_W-1:0]         dv;
  logic [$clog2(DIVD_W)-1:0] cnt;
  logic [DIVS_W:0]           r_sh;
  logic [DIVS_W:0]           r_sub;
  logic                      ge;

  assign r_sh  = {rem, dq[DIVD_W-1]};
  assign r_sub = r_sh - {1'b0, dv};
  assign ge    = r_sh >= {1'b0, dv};
  assign quot  = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      dq   <= dividend;
      dv   <= divisor;
      rem  <= '0;
    end else if (busy) begin
      rem <= ge ? r_sub[DIVS_W-1:0] : r_sh[DIVS_W-1:0];
      dq  <= {dq[DIVD_W-2:0], ge};
      cnt <= cnt + 1'b1;
      if (cnt == '1) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/cnb_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnb_dp
// Datapath: config registers, buffers, count store, divider, output register.
// ----------------------------------------------------------------------------
module cnb_dp import cnb_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output stat_t               stat,
  input  logic                cfg_valid,
  input  logic [CFG_IW-1:0]   cfg_index,
  input  logic [CFG_DW-1:0]   cfg_data,
  input  logic                in_valid,
  input  logic [OPCODE_W-1:0] opcode,
  input  logic [CIDX_W-1:0]   class_index,
  input  logic [FIDX_W-1:0]   feature_index,
  input  logic [FVAL_W-1:0]   feature_value,
  input  logic [AMT_W-1:0]    amount,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [CIDX_W-1:0]   result_class,
  output logic [PROB_W-1:0]   probability,
  output logic                last,
  output logic [STAT_W-1:0]   status
);

  function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] x,
                                                     input logic [AMT_W-1:0] y);
    logic [COUNT_WIDTH:0] s;
    s = {1'b0, x} + (COUNT_WIDTH+1)'(y);
    return s[COUNT_WIDTH] ? '1 : s[COUNT_WIDTH-1:0];
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] sat_quot(input logic [DIVD_W-1:0] q);
    return (q[DIVD_W-1:COUNT_WIDTH] != '0) ? '1 : q[COUNT_WIDTH-1:0];
  endfunction

  // configuration
  logic [CCNT_W-1:0] class_count;
  logic [FCNT_W-1:0] feature_count;
  logic [AMT_W-1:0]  alpha;
  logic [CLASS_W:0]  k;
  logic [FEAT_W:0]   nf;

  // latched item
  logic [OPCODE_W-1:0] op_q;
  logic [CIDX_W-1:0]   ci_q;
  logic [FIDX_W-1:0]   fi_q;
  logic [FVAL_W-1:0]   fv_q;
  logic [AMT_W-1:0]    amt_q;

  logic [AMT_W-1:0]       label [MAX_CLASSES];
  logic [COUNT_WIDTH-1:0] total [MAX_CLASSES];
  logic                   fvalid [MAX_FEATURES];
  logic                   cvalid [MAX_FEATURES];
  logic [MANT_W-1:0]      mant [MAX_CLASSES];
  logic signed [EXP_W-1:0] expo [MAX_CLASSES];

  logic [CLASS_W-1:0] cidx;
  logic [FEAT_W:0]    fidx;
  logic [ENT_W-1:0]   eidx;
  logic [CNT_AW-1:0]  clr_idx;
  logic [SUM_W-1:0]   sum;
  logic [WIDE_W-1:0]  m, num, den;
  logic signed [EXP_W-1:0] e, top;
  logic               have;
  logic [2*MANT_W-1:0] prod;
  logic [TOTAL_W-1:0] total_s;
  logic [CNT_AW-1:0]  addr_q;
  logic               rd_fvalid, rd_cvalid;

  // memories
  logic                   feat_we, card_we, cnt_we;
  logic [FEAT_W-1:0]      feat_addr;
  logic [VAL_W-1:0]       feat_rdata;
  logic [CARD_W-1:0]      card_wdata, card_rdata;
  logic [CNT_AW-1:0]      cnt_addr;
  logic [COUNT_WIDTH-1:0] cnt_wdata, cnt_rdata;

  // divider
  logic              div_start, div_busy;
  logic [DIVD_W-1:0] div_dividend, div_quot;
  logic [DIVS_W-1:0] div_divisor;

  logic [AMT_W-1:0]        lbl_c;
  logic [COUNT_WIDTH-1:0]  tot_c;
  logic [VAL_W-1:0]        fv_eff;
  logic [CARD_W-1:0]       card_eff;
  logic [CNT_AW-1:0]       rd_addr;
  logic [WIDE_W-1:0]       den_next, num_raw;
  logic                    c_last, out_free;
  logic [CLASS_W-1:0]      c_next;
  logic signed [EXP_W:0]   dsh;
  logic [MANT_W-1:0]       aligned;
  logic                    m_big;

  assign lbl_c    = label[cidx];
  assign tot_c    = total[cidx];
  assign fv_eff   = rd_fvalid ? feat_rdata : '0;
  assign card_eff = rd_cvalid ? card_rdata : CARD_W'(MAX_VALUES);
  assign rd_addr  = {cidx, fidx[FEAT_W-1:0], fv_eff};
  assign den_next = {1'b0, tot_c} + WIDE_W'(card_eff * alpha);
  assign num_raw  = {1'b0, cnt_rdata} + WIDE_W'(alpha);
  assign c_last   = ({1'b0, cidx} + 1'b1) == k;
  assign c_next   = c_last ? '0 : cidx + 1'b1;
  assign out_free = !out_valid || out_ready;
  assign m_big    = m[WIDE_W-1:MANT_W] != '0;
  assign dsh      = {top[EXP_W-1], top} - {expo[cidx][EXP_W-1], expo[cidx]};
  assign aligned  = (mant[cidx] == '0 || dsh >= $signed((EXP_W+1)'(ALIGN_LIMIT))) ? '0 :
                    mant[cidx] >> dsh[SH_W-1:0];

  always_comb begin
    if (class_count == '0) begin
      k = (CLASS_W+1)'(1);
    end else if (class_count > CCNT_W'(MAX_CLASSES)) begin
      k = (CLASS_W+1)'(MAX_CLASSES);
    end else begin
      k = (CLASS_W+1)'(class_count);
    end
    if (feature_count == '0) begin
      nf = (FEAT_W+1)'(1);
    end else if (feature_count > FCNT_W'(MAX_FEATURES)) begin
      nf = (FEAT_W+1)'(MAX_FEATURES);
    end else begin
      nf = (FEAT_W+1)'(feature_count);
    end
  end

  always_comb begin
    stat.clear_last = clr_idx == CNT_AW'(CNT_DEPTH - 1);
    stat.c_last     = c_last;
    stat.f_last     = (fidx + 1'b1) == nf;
    stat.f_end      = fidx == nf;
    stat.e_last     = eidx == '1;
    stat.sum_ok     = (sum + SUM_W'(SUM_TOL) >= SUM_W'(Q16_ONE)) &&
                      (sum <= SUM_W'(Q16_ONE + SUM_TOL));
    stat.norm_done  = !m_big && (m[MANT_W-1] || m == '0);
    stat.m_zero     = m == '0;
    stat.den_zero   = den == '0;
    stat.den_small  = den[WIDE_W-1:MANT_W] == '0;
    stat.div_busy   = div_busy;
    stat.out_free   = out_free;
    stat.amt_zero   = amt_q == '0;
    stat.op         = op_q;
  end

  // memory ports
  always_comb begin
    feat_we    = cmd.uop == U_EXEC && op_q == OP_SET_FEATURE &&
                 fv_q < FVAL_W'(MAX_VALUES) && fi_q <= FIDX_W'(MAX_FEATURES - 1);
    card_we    = cmd.uop == U_EXEC && op_q == OP_SET_CARD;
    feat_addr  = (feat_we || card_we) ? FEAT_W'(fi_q) : fidx[FEAT_W-1:0];
    if (fv_q == '0) begin
      card_wdata = CARD_W'(1);
    end else if (fv_q > FVAL_W'(MAX_VALUES)) begin
      card_wdata = CARD_W'(MAX_VALUES);
    end else begin
      card_wdata = CARD_W'(fv_q);
    end
    cnt_we    = 1'b0;
    cnt_wdata = '0;
    cnt_addr  = addr_q;
    case (cmd.uop)
      U_CLEAR: begin
        cnt_we   = 1'b1;
        cnt_addr = clr_idx;
      end
      U_CREAD: cnt_addr = rd_addr;
      U_TR_WRITE: begin
        cnt_we    = 1'b1;
        cnt_wdata = sat_add(cnt_rdata, lbl_c);
      end
      U_FG_READ: cnt_addr = {cidx, eidx};
      U_FG_WRITE: begin
        cnt_we    = 1'b1;
        cnt_addr  = {cidx, eidx};
        cnt_wdata = sat_quot(div_quot);
      end
      default: ;
    endcase
  end

  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    case (cmd.uop)
      U_PF_DIV: begin
        div_start    = 1'b1;
        div_dividend = DIVD_W'({num[MANT_W-1:0], {(MANT_W-1){1'b0}}});
        div_divisor  = DIVS_W'(den[MANT_W-1:0]);
      end
      U_PO_DIV: begin
        div_start    = 1'b1;
        div_dividend = DIVD_W'({mant[cidx], {Q_FRAC{1'b0}}}) + DIVD_W'(total_s >> 1);
        div_divisor  = DIVS_W'(total_s);
      end
      U_FG_TOTAL: begin
        div_start    = 1'b1;
        div_dividend = DIVD_W'({tot_c, {Q_FRAC{1'b0}}});
        div_divisor  = DIVS_W'(amt_q);
      end
      U_FG_DIV: begin
        div_start    = 1'b1;
        div_dividend = DIVD_W'({cnt_rdata, {Q_FRAC{1'b0}}});
        div_divisor  = DIVS_W'(amt_q);
      end
      default: ;
    endcase
  end

  cnb_ram #(.WIDTH(VAL_W), .DEPTH(MAX_FEATURES)) u_feat_ram (
    .clk(clk), .we(feat_we), .addr(feat_addr), .wdata(VAL_W'(fv_q)), .rdata(feat_rdata)
  );

  cnb_ram #(.WIDTH(CARD_W), .DEPTH(MAX_FEATURES)) u_card_ram (
    .clk(clk), .we(card_we), .addr(feat_addr), .wdata(card_wdata), .rdata(card_rdata)
  );

  cnb_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(CNT_DEPTH)) u_cnt_ram (
    .clk(clk), .we(cnt_we), .addr(cnt_addr), .wdata(cnt_wdata), .rdata(cnt_rdata)
  );

  cnb_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .busy(div_busy), .quot(div_quot)
  );

  // configuration and reset-valued state
  always_ff @(posedge clk) begin
    if (rst) begin
      class_count   <= CCNT_W'(2);
      feature_count <= FCNT_W'(MAX_FEATURES);
      alpha         <= AMT_W'(Q16_ONE);
      for (int i = 0; i < MAX_CLASSES; i++) begin
        label[i] <= '0;
        total[i] <= '0;
      end
      for (int i = 0; i < MAX_FEATURES; i++) begin
        fvalid[i] <= 1'b0;
        cvalid[i] <= 1'b0;
      end
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_CLASS_COUNT:   class_count   <= cfg_data[CCNT_W-1:0];
          REG_FEATURE_COUNT: feature_count <= cfg_data[FCNT_W-1:0];
          REG_ALPHA:         alpha         <= cfg_data[AMT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.uop == U_EXEC && op_q == OP_SET_LABEL &&
          ci_q <= CIDX_W'(MAX_CLASSES - 1)) begin
        label[CLASS_W'(ci_q)] <= amt_q;
      end
      if (feat_we) begin
        fvalid[feat_addr] <= 1'b1;
      end
      if (card_we) begin
        cvalid[feat_addr] <= 1'b1;
      end
      if (cmd.uop == U_TR_TOTAL) begin
        total[cidx] <= sat_add(tot_c, lbl_c);
      end
      if (cmd.uop == U_FG_TSET) begin
        total[cidx] <= sat_quot(div_quot);
      end
    end
  end

  // sequencing counters and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
      cidx    <= '0;
      fidx    <= '0;
      eidx    <= '0;
    end else begin
      if (cmd.load && in_valid) begin
        op_q    <= opcode;
        ci_q    <= class_index;
        fi_q    <= feature_index;
        fv_q    <= feature_value;
        amt_q   <= amount;
        cidx    <= '0;
        fidx    <= '0;
        eidx    <= '0;
        sum     <= '0;
        have    <= 1'b0;
        top     <= '0;
        total_s <= '0;
      end
      case (cmd.uop)
        U_CLEAR: clr_idx <= clr_idx + 1'b1;
        U_SUM: begin
          sum  <= sum + SUM_W'(lbl_c);
          cidx <= c_next;
        end
        U_TR_TOTAL: fidx <= '0;
        U_FREAD: begin
          rd_fvalid <= fvalid[fidx[FEAT_W-1:0]];
          rd_cvalid <= cvalid[fidx[FEAT_W-1:0]];
        end
        U_CREAD: begin
          addr_q <= rd_addr;
          den    <= den_next;
        end
        U_TR_WRITE: begin
          if (stat.f_last) begin
            fidx <= '0;
            cidx <= c_next;
          end else begin
            fidx <= fidx + 1'b1;
          end
        end
        U_PR_INIT: begin
          m    <= {1'b0, tot_c} + WIDE_W'(alpha);
          e    <= '0;
          fidx <= '0;
        end
        U_NORM: begin
          if (m_big) begin
            m <= m >> 1;
            e <= e + EXP_W'(1);
          end else if (m != '0 && !m[MANT_W-1]) begin
            m <= m << 1;
            e <= e - EXP_W'(1);
          end
        end
        U_PF_NUM: num <= (num_raw > den) ? den : num_raw;
        U_PF_SHIFT: begin
          if (!stat.den_small) begin
            den <= den >> 1;
            num <= num >> 1;
          end
        end
        U_F_NEXT: fidx <= fidx + 1'b1;
        U_PF_MUL: prod <= m[MANT_W-1:0] * div_quot[MANT_W-1:0];
        U_PF_PROD: begin
          m    <= WIDE_W'(prod >> (MANT_W - 1));
          fidx <= fidx + 1'b1;
        end
        U_PR_STORE: begin
          mant[cidx] <= m[MANT_W-1:0];
          expo[cidx] <= e;
          if (m != '0 && (!have || e > top)) begin
            top  <= e;
            have <= 1'b1;
          end
          cidx <= c_next;
        end
        U_AL: begin
          mant[cidx] <= aligned;
          total_s    <= total_s + TOTAL_W'(aligned);
          cidx       <= c_next;
        end
        U_PO_OUT: begin
          if (out_free) begin
            cidx <= c_next;
          end
        end
        U_FG_TSET: eidx <= '0;
        U_FG_WRITE: begin
          if (stat.e_last) begin
            eidx <= '0;
            cidx <= c_next;
          end else begin
            eidx <= eidx + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.uop == U_TR_RESULT && out_free) begin
      out_valid    <= 1'b1;
      result_class <= '0;
      probability  <= '0;
      last         <= 1'b1;
      status       <= stat.sum_ok ? ST_TRAIN_OK : ST_TRAIN_REJ;
    end else if (cmd.uop == U_PO_OUT && out_free) begin
      out_valid    <= 1'b1;
      result_class <= CIDX_W'(cidx);
      probability  <= (total_s == '0) ? '0 : div_quot[PROB_W-1:0];
      last         <= c_last;
      status       <= ST_PREDICT;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

FILE: rtl/cnb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnb_ctrl
// Sequencer for store clear, item loads, train, predict and forget.
// ----------------------------------------------------------------------------
module cnb_ctrl import cnb_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  input  logic  in_valid,
  output logic  in_ready,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:     if (stat.clear_last) state_next = S_IDLE;
      S_IDLE:      if (in_valid) state_next = S_EXEC;
      S_EXEC: begin
        unique case (stat.op)
          OP_TRAIN:   state_next = S_SUM;
          OP_PREDICT: state_next = S_PR_INIT;
          OP_FORGET:  state_next = stat.amt_zero ? S_IDLE : S_FG_TOTAL;
          default:    state_next = S_IDLE;
        endcase
      end
      S_SUM:       if (stat.c_last) state_next = S_SUM_CHK;
      S_SUM_CHK:   state_next = stat.sum_ok ? S_TR_TOTAL : S_TR_RESULT;
      S_TR_TOTAL:  state_next = S_TR_FREAD;
      S_TR_FREAD:  state_next = S_TR_CREAD;
      S_TR_CREAD:  state_next = S_TR_WRITE;
      S_TR_WRITE: begin
        if (!stat.f_last) begin
          state_next = S_TR_FREAD;
        end else begin
          state_next = stat.c_last ? S_TR_RESULT : S_TR_TOTAL;
        end
      end
      S_TR_RESULT: if (stat.out_free) state_next = S_IDLE;
      S_PR_INIT:   state_next = S_PR_NORM;
      S_PR_NORM: begin
        if (stat.norm_done) begin
          state_next = (stat.m_zero || stat.f_end) ? S_PR_STORE : S_PF_FREAD;
        end
      end
      S_PF_FREAD:  state_next = S_PF_CREAD;
      S_PF_CREAD:  state_next = S_PF_NUM;
      S_PF_NUM:    state_next = S_PF_SHIFT;
      S_PF_SHIFT: begin
        if (stat.den_zero) begin
          state_next = S_PF_SKIP;
        end else if (stat.den_small) begin
          state_next = S_PF_DIV;
        end
      end
      S_PF_SKIP:   state_next = S_PR_NORM;
      S_PF_DIV:    state_next = S_PF_WAIT;
      S_PF_WAIT:   if (!stat.div_busy) state_next = S_PF_MUL;
      S_PF_MUL:    state_next = S_PF_PROD;
      S_PF_PROD:   state_next = S_PR_NORM;
      S_PR_STORE:  state_next = stat.c_last ? S_AL : S_PR_INIT;
      S_AL:        if (stat.c_last) state_next = S_PO_DIV;
      S_PO_DIV:    state_next = S_PO_WAIT;
      S_PO_WAIT:   if (!stat.div_busy) state_next = S_PO_OUT;
      S_PO_OUT: begin
        if (stat.out_free) begin
          state_next = stat.c_last ? S_IDLE : S_PO_DIV;
        end
      end
      S_FG_TOTAL:  state_next = S_FG_TWAIT;
      S_FG_TWAIT:  if (!stat.div_busy) state_next = S_FG_TSET;
      S_FG_TSET:   state_next = S_FG_READ;
      S_FG_READ:   state_next = S_FG_DIV;
      S_FG_DIV:    state_next = S_FG_WAIT;
      S_FG_WAIT: begin
        if (!stat.div_busy) begin
          if (!stat.e_last) begin
            state_next = S_FG_READ;
          end else begin
            state_next = stat.c_last ? S_IDLE : S_FG_TOTAL;
          end
        end
      end
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd.load = 1'b0;
    cmd.uop  = U_NOP;
    unique case (state)
      S_CLEAR:     cmd.uop = U_CLEAR;
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = 1'b1;
        cmd.uop  = U_IDLE;
      end
      S_EXEC:      cmd.uop = U_EXEC;
      S_SUM:       cmd.uop = U_SUM;
      S_TR_TOTAL:  cmd.uop = U_TR_TOTAL;
      S_TR_FREAD:  cmd.uop = U_FREAD;
      S_TR_CREAD:  cmd.uop = U_CREAD;
      S_TR_WRITE:  cmd.uop = U_TR_WRITE;
      S_TR_RESULT: cmd.uop = U_TR_RESULT;
      S_PR_INIT:   cmd.uop = U_PR_INIT;
      S_PR_NORM:   cmd.uop = U_NORM;
      S_PF_FREAD:  cmd.uop = U_FREAD;
      S_PF_CREAD:  cmd.uop = U_CREAD;
      S_PF_NUM:    cmd.uop = U_PF_NUM;
      S_PF_SHIFT:  cmd.uop = U_PF_SHIFT;
      S_PF_SKIP:   cmd.uop = U_F_NEXT;
      S_PF_DIV:    cmd.uop = U_PF_DIV;
      S_PF_MUL:    cmd.uop = U_PF_MUL;
      S_PF_PROD:   cmd.uop = U_PF_PROD;
      S_PR_STORE:  cmd.uop = U_PR_STORE;
      S_AL:        cmd.uop = U_AL;
      S_PO_DIV:    cmd.uop = U_PO_DIV;
      S_PO_OUT:    cmd.uop = U_PO_OUT;
      S_FG_TOTAL:  cmd.uop = U_FG_TOTAL;
      S_FG_TSET:   cmd.uop = U_FG_TSET;
      S_FG_READ:   cmd.uop = U_FG_READ;
      S_FG_DIV:    cmd.uop = U_FG_DIV;
      S_FG_WAIT:   cmd.uop = stat.div_busy ? U_NOP : U_FG_WRITE;
      default:     cmd.uop = U_NOP;
    endcase
  end

endmodule

FILE: rtl/categorical_naive_bayes_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// categorical_naive_bayes_engine_core
// Categorical naive Bayes with soft labels and additive smoothing.
//
//   port group   dir   handshake             payload
//   in           in    in_valid / in_ready   opcode, class_index, feature_index,
//                                            feature_value, amount
//   out          out   out_valid / out_ready result_class, probability, last, status
//   cfg          in    cfg_valid / cfg_ready cfg_index, cfg_data
//
// After reset the count store is cleared, one entry a cycle (8192 entries);
// in_ready stays low until then. Predict runs the divider, one quotient
// bit per cycle, for each class and feature, between normalization shifts;
// forget runs it for each count entry of each class in use. The result
// register lets the next item in while the last result waits for out_ready.
// ----------------------------------------------------------------------------
module categorical_naive_bayes_engine_core import cnb_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_IW-1:0]   cfg_index,
  input  logic [CFG_DW-1:0]   cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OPCODE_W-1:0] opcode,
  input  logic [CIDX_W-1:0]   class_index,
  input  logic [FIDX_W-1:0]   feature_index,
  input  logic [FVAL_W-1:0]   feature_value,
  input  logic [AMT_W-1:0]    amount,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [CIDX_W-1:0]   result_class,
  output logic [PROB_W-1:0]   probability,
  output logic                last,
  output logic [STAT_W-1:0]   status
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  cnb_ctrl u_ctrl (
    .clk(clk), .rst(rst), .stat(stat), .in_valid(in_valid),
    .in_ready(in_ready), .cmd(cmd)
  );

  cnb_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .cfg_valid(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .opcode(opcode), .class_index(class_index),
    .feature_index(feature_index), .feature_value(feature_value), .amount(amount),
    .out_valid(out_valid), .out_ready(out_ready), .result_class(result_class),
    .probability(probability), .last(last), .status(status)
  );

endmodule

FILE: sim/categorical_naive_bayes_engine_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// categorical_naive_bayes_engine_core_tb
// Self-checking bench for the categorical naive Bayes core. A queue-fed
// driver sends label, feature, cardinality, train, predict and forget items
// with random gaps; a monitor with random back-pressure checks every result
// against a fixed-point model of the classifier, across several register
// settings written while the core is idle.
// ----------------------------------------------------------------------------
module categorical_naive_bayes_engine_core_tb;
  import cnb_pkg::*;

  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic [CIDX_W-1:0]   ci;
    logic [FIDX_W-1:0]   fi;
    logic [FVAL_W-1:0]   fv;
    logic [AMT_W-1:0]    amt;
  } item_t;

  typedef struct packed {
    logic [CIDX_W-1:0] cls;
    logic [PROB_W-1:0] prob;
    logic              lst;
    logic [STAT_W-1:0] stat;
  } prob_t;

  localparam longint unsigned CNT_MAX  = (64'd1 << COUNT_WIDTH) - 1;
  localparam longint unsigned M_LOW    = 64'd1 << 31;
  localparam longint unsigned M_HIGH   = 64'd1 << 32;
  localparam longint unsigned WIDE_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam logic [OPCODE_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_SPARE_B = 3'd7;

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;
  logic in_valid, in_ready;
  logic [OPCODE_W-1:0] opcode;
  logic [CIDX_W-1:0] class_index;
  logic [FIDX_W-1:0] feature_index;
  logic [FVAL_W-1:0] feature_value;
  logic [AMT_W-1:0] amount;
  logic out_valid, out_ready;
  logic [CIDX_W-1:0] result_class;
  logic [PROB_W-1:0] probability;
  logic last;
  logic [STAT_W-1:0] status;

  categorical_naive_bayes_engine_core i_dut (.*);

  // model state
  logic [CCNT_W-1:0] m_classes;
  logic [FCNT_W-1:0] m_features;
  logic [AMT_W-1:0]  m_alpha;
  logic [AMT_W-1:0]  label_wt [MAX_CLASSES];
  logic [VAL_W-1:0]  feat_val [MAX_FEATURES];
  int unsigned       card_tab [MAX_FEATURES];
  longint unsigned   tot_w [MAX_CLASSES];
  longint unsigned   value_count [CNT_DEPTH];

  item_t pending_q[$];
  prob_t expected_q[$];
  int    errors = 0;
  bit    in_taken = 1'b0;
  int    in_gap, out_gap;
  bit    idle_on;
  int    forgets_left;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int k_used();
    if (m_classes < 1) return 1;
    if (m_classes > MAX_CLASSES) return MAX_CLASSES;
    return m_classes;
  endfunction

  function automatic int nf_used();
    if (m_features < 1) return 1;
    if (m_features > MAX_FEATURES) return MAX_FEATURES;
    return m_features;
  endfunction

  function automatic longint unsigned sat_add(longint unsigned x, longint unsigned y,
                                              longint unsigned lim);
    return (x > lim - y) ? lim : x + y;
  endfunction

  function automatic longint unsigned shrink_count(longint unsigned x, longint unsigned d);
    longint unsigned q, r, res;
    q = x / d;
    r = x % d;
    if (q > (CNT_MAX >> 16)) return CNT_MAX;
    res = (q << 16) + ((r << 16) / d);
    return (res > CNT_MAX) ? CNT_MAX : res;
  endfunction

  function automatic void renorm(inout longint unsigned m, inout int e);
    while (m >= M_HIGH) begin
      m = m >> 1;
      e++;
    end
    if (m != 0)
      while (m < M_LOW) begin
        m = m << 1;
        e--;
      end
  endfunction

  function automatic int slot(int c, int f, int v);
    return (c * MAX_FEATURES + f) * MAX_VALUES + v;
  endfunction

  task automatic classify();
    int k, nf, e, top;
    bit have;
    longint unsigned a, t, m, num, den, total;
    longint unsigned mant [MAX_CLASSES];
    int expo [MAX_CLASSES];
    prob_t p;
    k = k_used();
    nf = nf_used();
    a = m_alpha;
    total = 0;
    top = 0;
    have = 0;
    for (int c = 0; c < k; c++) begin
      t = tot_w[c];
      m = sat_add(t, a, WIDE_MAX);
      e = 0;
      renorm(m, e);
      for (int f = 0; f < nf && m != 0; f++) begin
        num = sat_add(value_count[slot(c, f, feat_val[f])], a, WIDE_MAX);
        den = sat_add(t, card_tab[f] * a, WIDE_MAX);
        if (den == 0) continue;
        if (num > den) num = den;
        while (den >= M_HIGH) begin
          den = den >> 1;
          num = num >> 1;
        end
        m = (m * ((num << 31) / den)) >> 31;
        renorm(m, e);
      end
      mant[c] = m;
      expo[c] = e;
      if (m != 0 && (!have || e > top)) begin
        top = e;
        have = 1;
      end
    end
    for (int c = 0; c < k; c++) begin
      mant[c] = (mant[c] == 0 || top - expo[c] >= ALIGN_LIMIT) ? 0 : mant[c] >> (top - expo[c]);
      total += mant[c];
    end
    for (int c = 0; c < k; c++) begin
      p.cls = CIDX_W'(c);
      p.prob = total ? PROB_W'((mant[c] * Q16_ONE + total / 2) / total) : '0;
      p.lst = (c + 1 == k);
      p.stat = ST_PREDICT;
      expected_q.push_back(p);
    end
  endtask

  task automatic train();
    int k, nf;
    longint unsigned sum, w;
    prob_t p;
    k = k_used();
    nf = nf_used();
    sum = 0;
    for (int c = 0; c < k; c++) sum += label_wt[c];
    p = '{cls: '0, prob: '0, lst: 1'b1, stat: ST_TRAIN_REJ};
    if (!(sum + SUM_TOL < Q16_ONE || sum > Q16_ONE + SUM_TOL)) begin
      p.stat = ST_TRAIN_OK;
      for (int c = 0; c < k; c++) begin
        w = label_wt[c];
        tot_w[c] = sat_add(tot_w[c], w, CNT_MAX);
        for (int f = 0; f < nf; f++)
          value_count[slot(c, f, feat_val[f])] =
            sat_add(value_count[slot(c, f, feat_val[f])], w, CNT_MAX);
      end
    end
    expected_q.push_back(p);
  endtask

  task automatic apply_item(item_t it);
    int v;
    case (it.op)
      OP_SET_LABEL: label_wt[it.ci] = it.amt;
      OP_SET_FEATURE: if (it.fv < MAX_VALUES) feat_val[it.fi] = it.fv[VAL_W-1:0];
      OP_TRAIN: train();
      OP_PREDICT: classify();
      OP_FORGET:
        if (it.amt != 0)
          for (int c = 0; c < k_used(); c++) begin
            tot_w[c] = shrink_count(tot_w[c], it.amt);
            for (int i = slot(c, 0, 0); i < slot(c + 1, 0, 0); i++)
              value_count[i] = shrink_count(value_count[i], it.amt);
          end
      OP_SET_CARD: begin
        v = (it.fv < 1) ? 1 : it.fv;
        card_tab[it.fi] = (v > MAX_VALUES) ? MAX_VALUES : v;
      end
      default: ;
    endcase
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else if (in_valid && !in_taken) begin
      in_valid <= 1'b1;
    end else if (in_gap > 0) begin
      in_gap--;
      in_valid <= 1'b0;
    end else if (pending_q.size() > 0) begin
      item_t it;
      it = pending_q.pop_front();
      in_valid <= 1'b1;
      opcode <= it.op;
      class_index <= it.ci;
      feature_index <= it.fi;
      feature_value <= it.fv;
      amount <= it.amt;
      in_gap = gap_len();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_gap = 0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      out_gap = gap_len();
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_CLASSES; i++) begin
        label_wt[i] = '0;
        tot_w[i] = 0;
      end
      for (int i = 0; i < MAX_FEATURES; i++) begin
        feat_val[i] = '0;
        card_tab[i] = MAX_VALUES;
      end
      for (int i = 0; i < CNT_DEPTH; i++) value_count[i] = 0;
    end
    in_taken = in_valid && in_ready && !rst;
    if (in_taken) apply_item('{opcode, class_index, feature_index, feature_value, amount});
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected transfer cls=%0d prob=%0d last=%0b status=%0d",
                 $time, result_class, probability, last, status);
        errors++;
      end else begin
        prob_t p;
        p = expected_q.pop_front();
        if (p.cls !== result_class) begin
          $display("%0t: result_class expected %0d actual %0d", $time, p.cls, result_class);
          errors++;
        end
        if (p.prob !== probability) begin
          $display("%0t: probability expected %0d actual %0d", $time, p.prob, probability);
          errors++;
        end
        if (p.lst !== last) begin
          $display("%0t: last expected %0b actual %0b", $time, p.lst, last);
          errors++;
        end
        if (p.stat !== status) begin
          $display("%0t: status expected %0d actual %0d", $time, p.stat, status);
          errors++;
        end
      end
    end
  end

  task automatic push(logic [OPCODE_W-1:0] op, int ci, int fi, int fv, int amt);
    pending_q.push_back('{op, CIDX_W'(ci), FIDX_W'(fi), FVAL_W'(fv), AMT_W'(amt)});
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, int data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DW'(data);
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_CLASS_COUNT: m_classes = data[CCNT_W-1:0];
      REG_FEATURE_COUNT: m_features = data[FCNT_W-1:0];
      REG_ALPHA: m_alpha = data[AMT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  // one labelled sample followed by train or predict, a forget item, or a noise item
  task automatic gen_round(inout int cnt);
    int k, nf, r, rest, w, n;
    k = k_used();
    nf = nf_used();
    r = $urandom_range(0, 99);
    if (r < 8) begin
      push($urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B, $urandom, $urandom, $urandom,
           $urandom);
      cnt++;
    end else if (r < 12 && forgets_left > 0 && k <= 2) begin
      forgets_left--;
      push(OP_FORGET, 0, 0, 0, $urandom_range(0, 3) == 0 ?
           $urandom_range(0, 24'hFFFFFF) : $urandom_range(40000, 200000));
      cnt++;
    end else begin
      rest = Q16_ONE;
      for (int c = 0; c < k; c++) begin
        if ($urandom_range(0, 99) < 12) w = $urandom_range(0, 24'hFFFFFF);
        else if (c == k - 1) w = rest + $urandom_range(0, 2) - ((rest > 0) ? 1 : 0);
        else w = $urandom_range(0, rest);
        rest = (rest > w) ? rest - w : 0;
        push(OP_SET_LABEL, c, 0, 0, w);
        cnt++;
      end
      n = $urandom_range(0, (nf < 6) ? nf : 6);
      for (int i = 0; i < n; i++) begin
        push(OP_SET_FEATURE, $urandom, $urandom_range(0, nf - 1),
             $urandom_range(0, 19) == 0 ? $urandom_range(16, 31) : $urandom_range(0, 15),
             $urandom);
        cnt++;
      end
      if ($urandom_range(0, 9) == 0) begin
        push(OP_SET_CARD, 0, $urandom_range(0, 63), $urandom_range(0, 31), 0);
        cnt++;
      end
      push($urandom_range(0, 99) < 65 ? OP_TRAIN : OP_PREDICT, $urandom, $urandom,
           $urandom, $urandom);
      cnt++;
    end
  endtask

  task automatic run_phase(int k, int nf, int alpha, int quota);
    int cnt;
    write_reg(REG_CLASS_COUNT, k);
    write_reg(REG_FEATURE_COUNT, nf);
    write_reg(REG_ALPHA, alpha);
    idle_on = $urandom_range(0, 3) != 0;
    cnt = 0;
    while (cnt < quota) gen_round(cnt);
    push(OP_PREDICT, 0, 0, 0, 0);
    drain();
  endtask

  initial begin
    idle_on = 1;
    forgets_left = 3;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    m_classes = 2;
    m_features = 64;
    m_alpha = Q16_ONE;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset settings, empty model, extremes and special cases
    push(OP_PREDICT, 0, 0, 0, 0);
    push(OP_TRAIN, 0, 0, 0, 0);                  // sum zero: rejected
    push(OP_SET_LABEL, 7, 0, 0, 24'hFFFFFF);      // beyond classes in use
    push(OP_SET_LABEL, 0, 0, 0, 24'hFFFFFF);
    push(OP_TRAIN, 0, 0, 0, 0);                  // over: rejected
    push(OP_SET_LABEL, 0, 0, 0, 40000);
    push(OP_SET_LABEL, 1, 0, 0, 25537);           // one above 1.0
    push(OP_SET_FEATURE, 0, 0, 15, 0);
    push(OP_SET_FEATURE, 0, 63, 31, 0);           // value out of range: ignored
    push(OP_SET_FEATURE, 0, 5, 16, 0);
    push(OP_SET_FEATURE, 0, 63, 9, 0);
    push(OP_SET_CARD, 0, 0, 0, 0);                // clamped to one
    push(OP_SET_CARD, 0, 63, 31, 0);              // clamped to max
    push(OP_SET_CARD, 0, 1, 1, 0);                // stored value zero, within cardinality
    push(OP_TRAIN, 0, 0, 0, 0);
    push(OP_PREDICT, 0, 0, 0, 0);
    push(OP_FORGET, 0, 0, 0, 0);                  // zero divisor: no change
    push(OP_SPARE_A, 7, 63, 31, 24'hFFFFFF);
    push(OP_SPARE_B, 0, 0, 0, 0);
    push(OP_FORGET, 0, 0, 0, 131072);
    push(OP_PREDICT, 0, 0, 0, 0);
    drain();

    // zero alpha with an empty third class: its score is zero
    run_phase(3, 2, 0, 0);
    run_phase(1, 1, 0, 40);
    run_phase(8, 4, 24'hFFFFFF, 60);
    run_phase(15, 3, Q16_ONE, 50);
    run_phase(0, 0, $urandom_range(0, 24'hFFFFFF), 40);
    run_phase(2, 5, $urandom_range(1, 200000), 50);
    run_phase(5, 127, $urandom_range(1, 24'hFFFFFF), 12);
    run_phase(8, 64, 1, 8);
    run_phase(4, 6, $urandom_range(0, 100), 50);
    run_phase(7, 2, $urandom_range(0, 24'hFFFFFF), 50);

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
